### rtl/core/refcounted_handle_bump_allocator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the reference-counted handle bump allocator
// Immediate-implication and next-cycle-implication checks on clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_HANDLE_BUMP_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_HANDLE_BUMP_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define RHBA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RHBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RHBA_ASSERT_SAME(lbl, ante, cons, msg)
`define RHBA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/core/rhba_pkg.sv
// ----------------------------------------------------------------------------
// rhba_pkg
// Shared types, codes and defaults for the handle bump allocator.
// ----------------------------------------------------------------------------
package rhba_pkg;

  // Default parameter values.
  localparam int RHBA_TABLE_DEPTH  = 256;
  localparam int RHBA_HEADER_BYTES = 16;

  // Fixed field widths.
  localparam int BYTES_W  = 25;
  localparam int CLASS_W  = 32;
  localparam int COUNT_W  = 16;
  localparam int HANDLE_W = 8;
  localparam int REQ_W    = 3;
  localparam int STAT_W   = 2;
  localparam int NEXT_W   = 9;

  localparam logic [BYTES_W-1:0] HEAP_RESET = 25'h0010000;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;

  // Request codes; unused codes behave as a query.
  localparam logic [REQ_W-1:0] REQ_ALLOC   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FREE    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RETAIN  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_QUERY   = 3'd4;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_TABLE_FULL = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BAD_HANDLE = 2'd3;

  typedef enum logic {
    CTL_IDLE,
    CTL_EXEC
  } rhba_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;  // latch request and start the table read
    logic commit;   // apply the update and load the result register
  } rhba_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_hold;  // result register is full and not being taken
  } rhba_stat_t;

  // One handle-table entry as stored in the table RAM.
  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [BYTES_W-1:0] size;
    logic [BYTES_W-1:0] offset;
    logic [COUNT_W-1:0] count;
  } rhba_entry_t;

  // Result payload, packed from the lowest bit up as handle_out first.
  typedef struct packed {
    logic [HANDLE_W-1:0] objects_live;
    logic [BYTES_W-1:0]  bytes_used;
    logic                freed;
    logic [COUNT_W-1:0]  count_out;
    logic [BYTES_W-1:0]  data_offset;
    logic [BYTES_W-1:0]  size_out;
    logic [CLASS_W-1:0]  class_out;
    logic                live;
    logic [HANDLE_W-1:0] handle_out;
  } rhba_result_t;

endpackage

### rtl/core/rhba_ram.sv
// ----------------------------------------------------------------------------
// rhba_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rhba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/rhba_ctrl.sv
// ----------------------------------------------------------------------------
// rhba_ctrl
// Two-state sequencer: capture a request, then commit it once the result
// register can take the answer.
// ----------------------------------------------------------------------------
module rhba_ctrl
  import rhba_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  rhba_stat_t stat,
  output rhba_cmd_t  cmd
);

  rhba_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CTL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      CTL_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = CTL_EXEC;
        end
      end
      CTL_EXEC: begin
        if (!stat.out_hold) begin
          cmd.commit = 1'b1;
          state_nxt  = CTL_IDLE;
        end
      end
      default: begin
        state_nxt = CTL_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/rhba_dp.sv
// ----------------------------------------------------------------------------
// rhba_dp
// Datapath: request registers, heap counters, live bits, entry table RAM
// and the result register.
// ----------------------------------------------------------------------------
`include "refcounted_handle_bump_allocator_defines.svh"

module rhba_dp
  import rhba_pkg::*;
#(
  parameter int TABLE_DEPTH  = RHBA_TABLE_DEPTH,
  parameter int HEADER_BYTES = RHBA_HEADER_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rhba_cmd_t           cmd,
  output rhba_stat_t          stat,
  input  logic                cfg_we,
  input  logic [BYTES_W-1:0]  cfg_data,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [CLASS_W-1:0]  class_tag,
  input  logic [BYTES_W-1:0]  data_bytes,
  input  logic [HANDLE_W-1:0] handle,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STAT_W-1:0]   out_status,
  output rhba_result_t        out_result
);

  // Handles never pass 255, so at most 256 table rows are ever used.
  localparam int EFF_DEPTH = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;
  localparam int ADDR_W    = $clog2(EFF_DEPTH);
  localparam logic [16:0]        DEPTH_LIM = 17'(TABLE_DEPTH);
  localparam logic [BYTES_W:0]   HDR_26    = 26'(HEADER_BYTES);
  localparam logic [BYTES_W-1:0] HDR_25    = 25'(HEADER_BYTES);

  // Configuration and allocator state.
  logic [BYTES_W-1:0]   heap_r;
  logic [BYTES_W-1:0]   used_r, used_nxt;
  logic [NEXT_W-1:0]    next_r, next_nxt;
  logic [HANDLE_W-1:0]  lcnt_r, lcnt_nxt;
  logic [EFF_DEPTH-1:0] live_r, live_nxt;

  // Captured request.
  logic [REQ_W-1:0]    req_r;
  logic [CLASS_W-1:0]  cls_r;
  logic [BYTES_W-1:0]  sz_r;
  logic [HANDLE_W-1:0] h_r;
  logic [BYTES_W:0]    total_r;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]   stat_r, stat_nxt;
  rhba_result_t        res_r, res_nxt;

  // Table RAM.
  rhba_entry_t         rd_entry, wr_entry;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;

  logic [BYTES_W+1:0]  sum_27;
  logic                is_alloc, no_space, tbl_full, h_ok, kill;
  logic [COUNT_W-1:0]  cnt, new_cnt;

  rhba_ram #(
    .WIDTH($bits(rhba_entry_t)),
    .DEPTH(EFF_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_entry),
    .re   (cmd.capture),
    .raddr(handle[ADDR_W-1:0]),
    .rdata(rd_entry)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= req_type;
      cls_r   <= class_tag;
      sz_r    <= data_bytes;
      h_r     <= handle;
      total_r <= {1'b0, data_bytes} + HDR_26;
    end
    res_r  <= res_nxt;
    stat_r <= stat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_r      <= HEAP_RESET;
      used_r      <= '0;
      next_r      <= NEXT_W'(1);
      lcnt_r      <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        heap_r <= cfg_data;
      end
      used_r      <= used_nxt;
      next_r      <= next_nxt;
      lcnt_r      <= lcnt_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign stat.out_hold = out_valid_r && !out_ready;

  always_comb begin
    is_alloc = (req_r == REQ_ALLOC);
    sum_27   = {2'b00, used_r} + {1'b0, total_r};
    no_space = sum_27 > {2'b00, heap_r};
    tbl_full = ({8'b0, next_r} >= DEPTH_LIM) || (next_r > NEXT_W'(255));
    h_ok     = (h_r != '0) && ({1'b0, h_r} < next_r)
               && ({9'b0, h_r} < DEPTH_LIM) && live_r[h_r[ADDR_W-1:0]];
    cnt      = rd_entry.count;
    kill     = (req_r == REQ_FREE) || ((req_r == REQ_RELEASE) && (cnt <= COUNT_W'(1)));

    case (req_r)
      REQ_RETAIN:  new_cnt = (cnt != COUNT_MAX) ? cnt + COUNT_W'(1) : cnt;
      REQ_RELEASE: new_cnt = cnt - COUNT_W'(1);
      default:     new_cnt = cnt;
    endcase

    used_nxt      = used_r;
    next_nxt      = next_r;
    lcnt_nxt      = lcnt_r;
    live_nxt      = live_r;
    wr_en         = 1'b0;
    wr_addr       = h_r[ADDR_W-1:0];
    wr_entry      = rd_entry;
    stat_nxt      = stat_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
      res_nxt       = '0;
      if (is_alloc) begin
        if (no_space) begin
          stat_nxt = STAT_NO_SPACE;
        end else if (tbl_full) begin
          stat_nxt = STAT_TABLE_FULL;
        end else begin
          stat_nxt                        = STAT_OK;
          wr_en                           = 1'b1;
          wr_addr                         = next_r[ADDR_W-1:0];
          wr_entry.cls                    = cls_r;
          wr_entry.size                   = sz_r;
          wr_entry.offset                 = used_r + HDR_25;
          wr_entry.count                  = COUNT_W'(1);
          live_nxt[next_r[ADDR_W-1:0]]    = 1'b1;
          used_nxt                        = sum_27[BYTES_W-1:0];
          next_nxt                        = next_r + NEXT_W'(1);
          lcnt_nxt                        = lcnt_r + HANDLE_W'(1);
          res_nxt.handle_out              = next_r[HANDLE_W-1:0];
          res_nxt.live                    = 1'b1;
          res_nxt.class_out               = cls_r;
          res_nxt.size_out                = sz_r;
          res_nxt.data_offset             = used_r + HDR_25;
          res_nxt.count_out               = COUNT_W'(1);
        end
      end else if (!h_ok) begin
        stat_nxt           = STAT_BAD_HANDLE;
        res_nxt.handle_out = h_r;
      end else begin
        stat_nxt            = STAT_OK;
        res_nxt.handle_out  = h_r;
        res_nxt.size_out    = rd_entry.size;
        res_nxt.data_offset = rd_entry.offset;
        if (kill) begin
          wr_en                     = 1'b1;
          wr_entry.count            = '0;
          live_nxt[h_r[ADDR_W-1:0]] = 1'b0;
          lcnt_nxt                  = lcnt_r - HANDLE_W'(1);
          res_nxt.freed             = 1'b1;
        end else begin
          wr_en             = (req_r == REQ_RETAIN) || (req_r == REQ_RELEASE);
          wr_entry.count    = new_cnt;
          res_nxt.live      = 1'b1;
          res_nxt.class_out = rd_entry.cls;
          res_nxt.count_out = new_cnt;
        end
      end
      res_nxt.bytes_used   = used_nxt;
      res_nxt.objects_live = lcnt_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = stat_r;
  assign out_result = res_r;

  `RHBA_ASSERT_SAME(a_commit_free, cmd.commit, !(out_valid_r && !out_ready),
    "commit while the result register is held")
  `RHBA_ASSERT_NEXT(a_commit_valid, cmd.commit, out_valid_r,
    "no result presented after a commit")
  `RHBA_ASSERT_SAME(a_live_count, 1'b1, $countones(live_r) == int'(lcnt_r),
    "live counter disagrees with the live bits")
  `RHBA_ASSERT_SAME(a_null_dead, 1'b1, !live_r[0] && (next_r <= NEXT_W'(256)),
    "null handle live or next handle out of range")

endmodule

### rtl/core/refcounted_handle_bump_allocator.sv
// Each input transfer latches the request and starts the entry table read;
// the commit, which waits while the result register is held, then updates
// the table and loads the result. No new request is taken until the commit.
// A finished result waits in its own register while the next request is taken.
// Reset (rst_n, synchronous): heap_bytes returns to 65536, counters clear, all
// live bits clear at once; the table RAM needs and gets no clearing pass.
// ----------------------------------------------------------------------------
// refcounted_handle_bump_allocator
// Reference-counted object heap: a bump allocator with a handle table.
// ----------------------------------------------------------------------------
module refcounted_handle_bump_allocator
  import rhba_pkg::*;
#(
  parameter int TABLE_DEPTH  = RHBA_TABLE_DEPTH,
  parameter int HEADER_BYTES = RHBA_HEADER_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,

  // Configuration: heap_bytes, written on a cfg_valid/cfg_ready transfer.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [BYTES_W-1:0]  cfg_data,

  // Request stream.
  input  logic                in_tvalid,
  output logic                in_tready,
  // class_tag[31:0], data_bytes[56:32], handle[64:57], zero pad[71:65]
  input  logic [71:0]         in_tdata,
  // req_type[2:0]
  input  logic [REQ_W-1:0]    in_tuser,

  // Result stream.
  output logic                out_tvalid,
  input  logic                out_tready,
  // handle_out[7:0], live[8], class_out[40:9], size_out[65:41],
  // data_offset[90:66], count_out[106:91], freed[107], bytes_used[132:108],
  // objects_live[140:133], zero pad[143:141]
  output logic [143:0]        out_tdata,
  // status[1:0]
  output logic [STAT_W-1:0]   out_tuser
);

  rhba_cmd_t    cmd;
  rhba_stat_t   stat;
  rhba_result_t result;

  // The heap size register takes a write in any cycle; software must write it
  // only while no request is in flight, and the block leaves this to software.
  assign cfg_ready = 1'b1;

  // The controller sequences each request through capture and commit; all
  // arithmetic, table access and the result register live in the datapath.
  rhba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rhba_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .req_type  (in_tuser),
    .class_tag (in_tdata[31:0]),
    .data_bytes(in_tdata[56:32]),
    .handle    (in_tdata[64:57]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_status(out_tuser),
    .out_result(result)
  );

  // The result struct is declared in tdata order, lowest field last.
  assign out_tdata = {3'b000, result};

endmodule
